// ===== sv/crcfd_pkg.sv =====
package crcfd_pkg;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned QueueDepth  = 4;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'h1021;

  // configuration register indexes
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_MAXLEN  = 2'd2;

  localparam logic [7:0]  StartReset   = 8'hAA;
  localparam logic [7:0]  VersionReset = 8'h01;
  localparam logic [15:0] MaxLenReset  = 16'd4096;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_END  = 2'd2,
    KIND_DROP = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_START_ERR = 3'd1,
    ST_VER_ERR   = 3'd2,
    ST_LEN_ERR   = 3'd3,
    ST_CRC_ERR   = 3'd4
  } status_e;

  // classified word passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [15:0] seq;
    logic [15:0] op;
    logic [15:0] len;
    logic [7:0]  data;
    status_e     status;
    logic [15:0] recv;
    logic [63:0] hdr;
  } item_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC over the 8 header bytes from the init value; a fixed XOR matrix
  function automatic logic [15:0] crc_header(input logic [63:0] hdr);
    logic [15:0] c;
    c = CrcInit;
    for (int i = 0; i < 8; i++) begin
      c = crc_byte(c, hdr[63-8*i -: 8]);
    end
    return c;
  endfunction

endpackage

// ===== sv/crc_checked_frame_deframer.sv =====
// Channel   Direction  Handshake          Word
// rx        in         push_i / full_o    rx_byte_i
// result    out        empty_o / pop_i    kind_o .. crc_received_o
// cfg       in         cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One byte per cycle while full_o is low; a result reaches the outputs through the
// queue write and then the output register load, and is held back while pop_i stalls.
// Header CRC is one XOR matrix over the 8 header bytes; payload CRC is one
// byte step per cycle in the back while pop_i does not hold it.
// A four-word queue lets the front keep taking bytes while pop_i is low;
// full_o rises when it fills. Reset is asynchronous and leaves no clearing pass.
module crc_checked_frame_deframer import crcfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  kind_o,
  output logic [15:0] sequence_res_o,
  output logic [15:0] opcode_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  data_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  output logic [15:0] crc_computed_o,
  output logic [15:0] crc_received_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  q_ctl_t  qctl;
  q_sts_t  qsts;
  item_t   f_item, q_item;
  logic    f_push, b_take;
  kind_e   kind;
  status_e status;

  assign full_o   = qsts.full;
  assign qctl.push = f_push;
  assign qctl.pop  = b_take;
  assign kind_o   = kind;
  assign status_o = status;

  crcfd_front u_front (
    .clk_i, .rst_ni,
    .accept_i    (push_i && !qsts.full),
    .rx_byte_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push_o      (f_push),
    .item_o      (f_item)
  );

  crcfd_fifo u_fifo (
    .clk_i, .rst_ni,
    .ctl_i   (qctl),
    .wdata_i (f_item),
    .rdata_o (q_item),
    .sts_o   (qsts)
  );

  crcfd_back u_back (
    .clk_i, .rst_ni,
    .item_i   (q_item),
    .avail_i  (!qsts.empty),
    .take_o   (b_take),
    .pop_i    (pop_i && !empty_o),
    .empty_o,
    .kind_o   (kind),
    .sequence_res_o, .opcode_o, .payload_length_o, .data_o, .last_o,
    .status_o (status),
    .crc_computed_o, .crc_received_o
  );

`ifndef NO_ASSERTIONS
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (last_o == (kind == KIND_END))) else $error("last mismatch");
  a_end_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && kind == KIND_END && status == ST_OK) |->
    (crc_computed_o == crc_received_o)) else $error("crc status wrong");
  a_drop_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && kind == KIND_DROP) |->
    (status == ST_START_ERR || status == ST_VER_ERR || status == ST_LEN_ERR))
    else $error("discard without cause");
`endif

endmodule

// ===== sv/crcfd_fifo.sv =====
module crcfd_fifo import crcfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_ctl_t ctl_i,
  input  item_t  wdata_i,
  output item_t  rdata_o,
  output q_sts_t sts_o
);

  localparam int unsigned AW = $clog2(QueueDepth);

  item_t mem_q [QueueDepth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;

  assign sts_o.full  = (cnt_q == (AW+1)'(QueueDepth));
  assign sts_o.empty = (cnt_q == '0);
  assign rdata_o     = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (ctl_i.push) wptr_q <= wptr_q + 1'b1;
      if (ctl_i.pop)  rptr_q <= rptr_q + 1'b1;
      if (ctl_i.push && !ctl_i.pop) cnt_q <= cnt_q + 1'b1;
      else if (!ctl_i.push && ctl_i.pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== sv/crcfd_front.sv =====
module crcfd_front import crcfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        push_o,
  output item_t       item_o
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  win_q [HeaderBytes];
  logic [7:0]  win_d [HeaderBytes];
  logic [7:0]  win_n [HeaderBytes];
  logic [2:0]  fill_q, fill_d;
  logic [15:0] rem_q, rem_d;
  logic        hi_wait_q, hi_wait_d;
  logic [7:0]  hi_q, hi_d;
  logic [7:0]  start_q, ver_q;
  logic [15:0] maxlen_q;
  logic [15:0] len_n;
  status_e     st;

  // window with the new byte in place
  always_comb begin
    for (int i = 0; i < HeaderBytes; i++) begin
      win_n[i] = (3'(i) == fill_q) ? rx_byte_i : win_q[i];
    end
    len_n = {win_n[6], win_n[7]};
    if (win_n[0] != start_q)      st = ST_START_ERR;
    else if (win_n[1] != ver_q)   st = ST_VER_ERR;
    else if (len_n > maxlen_q)    st = ST_LEN_ERR;
    else                          st = ST_OK;
  end

  // classify the accepted byte
  always_comb begin
    phase_d   = phase_q;
    win_d     = win_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    hi_wait_d = hi_wait_q;
    hi_d      = hi_q;
    push_o    = 1'b0;
    item_o    = '0;
    if (accept_i) begin
      case (phase_q)
        PH_PAYLOAD: begin
          push_o      = 1'b1;
          item_o.kind = KIND_DATA;
          item_o.data = rx_byte_i;
          rem_d       = rem_q - 1'b1;
          if (rem_q == 16'd1) begin
            phase_d   = PH_CHECK;
            hi_wait_d = 1'b1;
          end
        end
        PH_CHECK: begin
          if (hi_wait_q) begin
            hi_d      = rx_byte_i;
            hi_wait_d = 1'b0;
          end else begin
            push_o      = 1'b1;
            item_o.kind = KIND_END;
            item_o.recv = {hi_q, rx_byte_i};
            phase_d     = PH_HUNT;
            fill_d      = '0;
            rem_d       = '0;
            hi_d        = '0;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          win_d   = win_n;
          if (fill_q != 3'(HeaderBytes - 1)) begin
            fill_d = fill_q + 1'b1;
          end else if (st != ST_OK) begin
            // drop the oldest byte and keep hunting
            for (int i = 0; i < HeaderBytes - 1; i++) win_d[i] = win_n[i+1];
            win_d[HeaderBytes-1] = '0;
            fill_d        = 3'(HeaderBytes - 1);
            push_o        = 1'b1;
            item_o.kind   = KIND_DROP;
            item_o.status = st;
          end else begin
            push_o      = 1'b1;
            item_o.kind = KIND_HDR;
            item_o.seq  = {win_n[2], win_n[3]};
            item_o.op   = {win_n[4], win_n[5]};
            item_o.len  = len_n;
            item_o.hdr  = {win_n[0], win_n[1], win_n[2], win_n[3],
                           win_n[4], win_n[5], win_n[6], win_n[7]};
            fill_d      = '0;
            rem_d       = len_n;
            if (len_n == '0) begin
              phase_d   = PH_CHECK;
              hi_wait_d = 1'b1;
            end else begin
              phase_d   = PH_PAYLOAD;
            end
          end
        end
      endcase
    end
  end

  // state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      for (int i = 0; i < HeaderBytes; i++) win_q[i] <= '0;
      fill_q    <= '0;
      rem_q     <= '0;
      hi_wait_q <= 1'b0;
      hi_q      <= '0;
      start_q   <= StartReset;
      ver_q     <= VersionReset;
      maxlen_q  <= MaxLenReset;
    end else begin
      phase_q   <= phase_d;
      win_q     <= win_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      hi_wait_q <= hi_wait_d;
      hi_q      <= hi_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START:   start_q  <= cfg_wdata_i[7:0];
          REG_VERSION: ver_q    <= cfg_wdata_i[7:0];
          REG_MAXLEN:  maxlen_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sv/crcfd_back.sv =====
module crcfd_back import crcfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  item_t       item_i,
  input  logic        avail_i,
  output logic        take_o,
  input  logic        pop_i,
  output logic        empty_o,
  output kind_e       kind_o,
  output logic [15:0] sequence_res_o,
  output logic [15:0] opcode_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  data_o,
  output logic        last_o,
  output status_e     status_o,
  output logic [15:0] crc_computed_o,
  output logic [15:0] crc_received_o
);

  logic        valid_q;
  logic [15:0] crc_q, crc_d;

  // load the output word when it is free or being popped
  assign take_o  = avail_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;

  always_comb begin
    crc_d = crc_q;
    case (item_i.kind)
      KIND_HDR:  crc_d = crc_header(item_i.hdr);
      KIND_DATA: crc_d = crc_byte(crc_q, item_i.data);
      default:   crc_d = crc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      crc_q   <= CrcInit;
    end else begin
      if (take_o) begin
        valid_q <= 1'b1;
        crc_q   <= crc_d;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      kind_o           <= item_i.kind;
      sequence_res_o   <= item_i.seq;
      opcode_o         <= item_i.op;
      payload_length_o <= item_i.len;
      data_o           <= item_i.data;
      last_o           <= (item_i.kind == KIND_END);
      crc_computed_o   <= (item_i.kind == KIND_END) ? crc_q : '0;
      crc_received_o   <= item_i.recv;
      if (item_i.kind == KIND_END) begin
        status_o <= (item_i.recv == crc_q) ? ST_OK : ST_CRC_ERR;
      end else begin
        status_o <= item_i.status;
      end
    end
  end

endmodule

// ===== sim/tb_crc_checked_frame_deframer.sv =====
`timescale 1ns / 100ps

module tb_crc_checked_frame_deframer;
  import crcfd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 12;

  // one expected result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [15:0] op;
    logic [15:0] len;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  status;
    logic [15:0] crc_c;
    logic [15:0] crc_r;
  } word_t;

  // directed row: byte plus optional typed expectation
  typedef struct {
    logic [7:0] b;
    bit         has_exp;
    word_t      exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [7:0]  rx_byte_i = '0;
  logic        pop_i = 1'b0;
  logic        empty_o;
  logic [1:0]  kind_o;
  logic [15:0] sequence_res_o, opcode_o, payload_length_o;
  logic [7:0]  data_o;
  logic        last_o;
  logic [2:0]  status_o;
  logic [15:0] crc_computed_o, crc_received_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  crc_checked_frame_deframer dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  m_start, m_ver;
  logic [15:0] m_max;
  logic [7:0]  win [HeaderBytes];
  int unsigned fill;
  logic [1:0]  ph;
  logic [15:0] remain, crc_run;
  logic [7:0]  crc_hi;

  word_t       pending_words[$];
  int          fails = 0;
  int unsigned cycles = 0;
  int unsigned n_words = 0, n_frames = 0, n_drops = 0, n_crc_bad = 0;
  int          send_idle = 0, recv_stall = 0;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    return r;
  endfunction

  task automatic deframer_reset();
    m_start = StartReset; m_ver = VersionReset; m_max = MaxLenReset;
    foreach (win[i]) win[i] = '0;
    fill = 0; ph = 2'd0; remain = '0; crc_run = CrcInit; crc_hi = '0;
  endtask

  // returns 1 and fills w when the byte causes a result
  function automatic bit deframe_byte(logic [7:0] b, output word_t w);
    logic [15:0] recv, len;
    logic [2:0]  st;
    w = '0;
    if (ph == 2'd1) begin
      crc_run = crc_step(crc_run, b);
      remain = remain - 16'd1;
      if (remain == 0) begin ph = 2'd2; remain = 16'd2; end
      w.kind = KIND_DATA; w.data = b;
      return 1;
    end
    if (ph == 2'd2) begin
      if (remain > 1) begin
        crc_hi = b; remain = remain - 16'd1;
        return 0;
      end
      recv = {crc_hi, b};
      w.kind = KIND_END; w.last = 1'b1;
      w.status = (recv == crc_run) ? ST_OK : ST_CRC_ERR;
      w.crc_c = crc_run; w.crc_r = recv;
      ph = 2'd0; fill = 0; remain = '0; crc_run = CrcInit; crc_hi = '0;
      return 1;
    end
    ph = 2'd0;
    if (fill >= HeaderBytes) fill = HeaderBytes - 1;
    win[fill] = b;
    fill++;
    if (fill < HeaderBytes) return 0;
    len = {win[6], win[7]};
    st = ST_OK;
    if (win[0] != m_start) st = ST_START_ERR;
    else if (win[1] != m_ver) st = ST_VER_ERR;
    else if (len > m_max) st = ST_LEN_ERR;
    if (st != ST_OK) begin
      for (int i = 0; i < HeaderBytes - 1; i++) win[i] = win[i+1];
      win[HeaderBytes-1] = '0;
      fill = HeaderBytes - 1;
      w.kind = KIND_DROP; w.status = st;
      return 1;
    end
    crc_run = CrcInit;
    for (int i = 0; i < HeaderBytes; i++) crc_run = crc_step(crc_run, win[i]);
    fill = 0;
    if (len == 0) begin ph = 2'd2; remain = 16'd2; end
    else begin ph = 2'd1; remain = len; end
    w.kind = KIND_HDR; w.seq = {win[2], win[3]}; w.op = {win[4], win[5]}; w.len = len;
    return 1;
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_crc_checked_frame_deframer NOT OK");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    word_t e;
    if (rst_ni && pop_i && !empty_o) begin
      n_words++;
      if (pending_words.size() == 0) begin
        $error("unexpected result word kind=%0d", kind_o);
        fails++;
      end else begin
        e = pending_words.pop_front();
        if (kind_o !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind_o); fails++; end
        if (sequence_res_o !== e.seq) begin
          $error("sequence_res exp %h got %h", e.seq, sequence_res_o); fails++; end
        if (opcode_o !== e.op) begin
          $error("opcode exp %h got %h", e.op, opcode_o); fails++; end
        if (payload_length_o !== e.len) begin
          $error("payload_length exp %h got %h", e.len, payload_length_o); fails++; end
        if (data_o !== e.data) begin
          $error("data exp %h got %h", e.data, data_o); fails++; end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); fails++; end
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); fails++; end
        if (crc_computed_o !== e.crc_c) begin
          $error("crc_computed exp %h got %h", e.crc_c, crc_computed_o); fails++; end
        if (crc_received_o !== e.crc_r) begin
          $error("crc_received exp %h got %h", e.crc_r, crc_received_o); fails++; end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    pop_i <= ($urandom_range(99) >= recv_stall);
  end

  task automatic push_byte(logic [7:0] b, bit has_exp, word_t typed);
    word_t w;
    while ($urandom_range(99) < send_idle) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    if (deframe_byte(b, w)) begin
      if (has_exp && w != typed) begin
        $error("directed row expectation %h differs from prediction %h", typed, w);
        fails++;
      end
      pending_words.push_back(w);
      if (w.kind == KIND_END) begin
        n_frames++;
        if (w.status == ST_CRC_ERR) n_crc_bad++;
      end
      if (w.kind == KIND_DROP) n_drops++;
    end
    @(negedge clk_i);
  endtask

  task automatic settle();
    push_i <= 1'b0;
    @(negedge clk_i);
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_START) m_start = val[7:0];
    else if (idx == REG_VERSION) m_ver = val[7:0];
    else if (idx == REG_MAXLEN) m_max = val;
  endtask

  // builds one frame and sends it; bad_kind: 0 good, 1 bad crc, 2 bad header
  task automatic send_frame(int unsigned len, int unsigned bad_kind);
    logic [7:0]  f[$];
    logic [15:0] c;
    f.push_back(m_start);
    f.push_back(m_ver);
    repeat (4) f.push_back(8'($urandom_range(255)));
    f.push_back(len[15:8]); f.push_back(len[7:0]);
    if (bad_kind == 2) f[$urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    repeat (len) f.push_back(8'($urandom_range(255)));
    c = CrcInit;
    foreach (f[i]) c = crc_step(c, f[i]);
    if (bad_kind == 1) c ^= 16'(1 << $urandom_range(15));
    f.push_back(c[15:8]); f.push_back(c[7:0]);
    foreach (f[i]) push_byte(f[i], 0, '0);
  endtask

  task automatic random_phase(int unsigned n_bytes);
    int unsigned sent;
    int unsigned r, len;
    sent = 0;
    while (sent < n_bytes) begin
      r = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(m_max > 40 ? 40 : m_max)
                                     : $urandom_range(6);
      if (len > m_max) len = m_max;
      if (r < 70) send_frame(len, 0);
      else if (r < 82) send_frame(len, 1);
      else if (r < 90) send_frame(len, 2);
      else begin
        len = 0;
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)), 0, '0);
      end
      sent += len + 10;
    end
  endtask

  function automatic word_t drop_word(logic [2:0] st);
    word_t w;
    w = '0; w.kind = KIND_DROP; w.status = st;
    return w;
  endfunction

  function automatic word_t hdr_word(logic [15:0] seq, logic [15:0] op, logic [15:0] len);
    word_t w;
    w = '0; w.kind = KIND_HDR; w.seq = seq; w.op = op; w.len = len;
    return w;
  endfunction

  initial begin
    row_t  rows[$];
    deframer_reset();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: the window slides over bad start, bad version, over-limit
    // length, more bad starts, then a zero-length header and its check word
    rows.push_back('{8'h55, 0, '0});
    rows.push_back('{8'hAA, 0, '0});
    rows.push_back('{8'hAA, 0, '0});
    rows.push_back('{8'h01, 0, '0});
    rows.push_back('{8'h12, 0, '0});
    rows.push_back('{8'h34, 0, '0});
    rows.push_back('{8'h56, 0, '0});
    rows.push_back('{8'h78, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'hFF, 1, drop_word(ST_VER_ERR)});
    rows.push_back('{8'hFF, 1, drop_word(ST_LEN_ERR)});
    rows.push_back('{8'hAA, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'h01, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'h12, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'h34, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'h56, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'h78, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'h00, 1, drop_word(ST_START_ERR)});
    rows.push_back('{8'h00, 1, hdr_word(16'h1234, 16'h5678, 16'h0000)});
    rows.push_back('{8'h00, 0, '0});
    rows.push_back('{8'h00, 0, '0});
    foreach (rows[i]) push_byte(rows[i].b, rows[i].has_exp, rows[i].exp);
    rows.delete();
    // flush window with bytes, predictor tracks it
    repeat (8) push_byte(8'hAA, 0, '0);
    settle();
    // zero length limit: zero-length frames with good and bad check words
    write_reg(REG_MAXLEN, 16'd0);
    send_frame(0, 0);
    send_frame(0, 1);
    settle();

    // configuration sweep, extremes included
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        default: begin send_idle = 20; recv_stall = 20; end
      endcase
      write_reg(REG_START, (p == 1) ? 16'h00 : (p == 2) ? 16'hFF : 16'($urandom_range(255)));
      write_reg(REG_VERSION, (p == 3) ? 16'h00 : (p == 4) ? 16'hFF : 16'($urandom_range(255)));
      write_reg(REG_MAXLEN, (p == 5) ? 16'hFFFF : (p == 6) ? 16'd16 :
                            (p == 7) ? 16'd3 : MaxLenReset);
      random_phase(80);
      settle();
    end

    $display("covered %0d result words: %0d frame ends (%0d bad crc), %0d discards",
             n_words, n_frames, n_crc_bad, n_drops);
    if (fails == 0) begin
      $display("tb_crc_checked_frame_deframer OK");
    end else begin
      $display("tb_crc_checked_frame_deframer NOT OK");
    end
    $finish;
  end

endmodule
